/* rtl/tsd_pkg.sv */
// Shared types, codes and constants of the tone sequence synthesizer.
// Holds the quarter-wave sine table and the full-wave lookup function.
// No dependencies.
`default_nettype none

package tsd_pkg;

    typedef logic [1:0] kind_t;

    // Item kinds.
    localparam kind_t KIND_LOAD  = 2'd0;
    localparam kind_t KIND_START = 2'd1;
    localparam kind_t KIND_STOP  = 2'd2;
    localparam kind_t KIND_TICK  = 2'd3;

    localparam logic [15:0] RATE_DEFAULT = 16'd16000;
    localparam logic [15:0] MS_PER_SEC   = 16'd1000;
    localparam logic [7:0]  GAIN_MAX     = 8'd100;
    localparam logic [15:0] SINE_FULL    = 16'd32767;

    // round(32767 * sin(k * pi / 128)) for k = 0 .. 64.
    localparam logic [15:0] QUARTER_SINE [0:64] = '{
        16'd0,     16'd804,   16'd1608,  16'd2410,  16'd3212,  16'd4011,
        16'd4808,  16'd5602,  16'd6393,  16'd7179,  16'd7962,  16'd8739,
        16'd9512,  16'd10278, 16'd11039, 16'd11793, 16'd12539, 16'd13279,
        16'd14010, 16'd14732, 16'd15446, 16'd16151, 16'd16846, 16'd17530,
        16'd18204, 16'd18868, 16'd19519, 16'd20159, 16'd20787, 16'd21403,
        16'd22005, 16'd22594, 16'd23170, 16'd23731, 16'd24279, 16'd24811,
        16'd25329, 16'd25832, 16'd26319, 16'd26790, 16'd27245, 16'd27683,
        16'd28105, 16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956,
        16'd30273, 16'd30571, 16'd30852, 16'd31113, 16'd31356, 16'd31580,
        16'd31785, 16'd31971, 16'd32137, 16'd32285, 16'd32412, 16'd32521,
        16'd32609, 16'd32678, 16'd32728, 16'd32757, 16'd32767
    };

    // Full-wave sine from the quarter table by mirror symmetry.
    function automatic logic signed [16:0] sine_value(input logic [7:0] idx);
        logic [7:0]  mirror;
        logic [6:0]  k;
        logic [15:0] mag;
        mirror = 8'd128 - {1'b0, idx[6:0]};
        k = (idx[6:0] > 7'd64) ? mirror[6:0] : idx[6:0];
        mag = QUARTER_SINE[k];
        if (idx[7])
        begin
            return -$signed({1'b0, mag});
        end
        return $signed({1'b0, mag});
    endfunction

endpackage

`default_nettype wire

/* rtl/tsd_if.sv */
// Channel interfaces of the tone sequence synthesizer: configuration,
// input items and result items, each with valid/ready handshake.
// Depends on tsd_pkg.
`default_nettype none

interface tsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tsd_item_if;
    import tsd_pkg::*;

    logic        valid;
    logic        ready;
    kind_t       kind;
    logic [3:0]  slot_index;
    logic [15:0] tone_hz;
    logic [15:0] duration_ms;
    logic [7:0]  step_count;
    logic [7:0]  gain_pct;

    modport source (output valid, output kind, output slot_index, output tone_hz,
                    output duration_ms, output step_count, output gain_pct,
                    input ready);
    modport sink (input valid, input kind, input slot_index, input tone_hz,
                  input duration_ms, input step_count, input gain_pct,
                  output ready);
endinterface

interface tsd_result_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] sample;
    logic               active;
    logic [4:0]         current_step;

    modport source (output valid, output sample, output active, output current_step,
                    input ready);
    modport sink (input valid, input sample, input active, input current_step,
                  output ready);
endinterface

`default_nettype wire

/* rtl/tsd_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module tsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                            clk,
    input  logic                                            we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1) - 1:0]  waddr,
    input  logic [WIDTH-1:0]                                wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1) - 1:0]  raddr,
    output logic [WIDTH-1:0]                                rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/tone_sequence_dds.sv */
// Tone sequence synthesizer: load, stop and config items complete when taken. A tick
// item whose step continues passes the check and scale states; its sample enters the
// output register as the block frees the input, unless a full output register holds
// it. A step start (on a start item or a tick crossing a step boundary) runs a slot
// RAM read, a reciprocal multiply for the length and a 48-bit division for the phase
// increment; a rest skips the division. Reset (rst_n, async, low) leaves it idle.
`default_nettype none

module tone_sequence_dds #(
    parameter int STEP_SLOTS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    tsd_cfg_if.sink          cfg,
    tsd_item_if.sink         item_in,
    tsd_result_if.source     result_out
);

    import tsd_pkg::*;

    // Step counters must hold the slot count itself; RAM addresses only index.
    localparam int SW = $clog2(STEP_SLOTS + 1);
    localparam int AW = (STEP_SLOTS > 1) ? $clog2(STEP_SLOTS) : 1;
    localparam logic [7:0]    SLOTS_8  = 8'(STEP_SLOTS);
    localparam logic [SW-1:0] STEP_ONE = SW'(1);
    localparam logic [5:0]    DIV_LAST = 6'd47;
    // ceil(2^38 / 1000): multiplying by it and dropping 38 bits divides any
    // 32-bit value by 1000 exactly.
    localparam logic [28:0]   DUR_RECIP = 29'd274877907;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_BEGIN     = 3'd1;
    localparam logic [2:0] ST_READ      = 3'd2;
    localparam logic [2:0] ST_DIV_DUR   = 3'd3;
    localparam logic [2:0] ST_DIV_PHASE = 3'd4;
    localparam logic [2:0] ST_CHECK     = 3'd5;
    localparam logic [2:0] ST_SCALE     = 3'd6;

    logic [2:0]         state_reg, state_next;
    logic [15:0]        rate_reg, rate_next;
    logic [SW-1:0]      play_count_reg, play_count_next;
    logic [SW-1:0]      step_now_reg, step_now_next;
    logic [31:0]        samples_done_reg, samples_done_next;
    logic [31:0]        samples_in_step_reg, samples_in_step_next;
    logic [31:0]        phase_acc_reg, phase_acc_next;
    logic [31:0]        phase_step_reg, phase_step_next;
    logic [6:0]         gain_reg, gain_next;
    logic               from_tick_reg, from_tick_next;
    logic [15:0]        pitch_reg, pitch_next;
    logic [47:0]        dvd_reg, dvd_next;
    logic [16:0]        rem_reg, rem_next;
    logic [15:0]        divisor_reg, divisor_next;
    logic [5:0]         div_cnt_reg, div_cnt_next;
    logic [31:0]        prod_reg, prod_next;
    logic               act_reg, act_next;
    logic [4:0]         idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [13:0] out_sample_reg, out_sample_next;
    logic               out_active_reg, out_active_next;
    logic [4:0]         out_step_reg, out_step_next;

    logic        in_fire;
    logic        out_free;
    logic [15:0] rate_used;
    logic [7:0]  slot_wide;
    logic [7:0]  step_wide;
    logic        slot_ok;
    logic [7:0]  count_clamped;
    logic [7:0]  gain_clamped;
    logic        playing;
    logic        step_done;
    logic        ram_we;
    logic [31:0] ram_rdata;

    // Divider step, sine product and scaling.
    logic [16:0]        div_shifted;
    logic               div_ge;
    logic [16:0]        rem_step;
    logic [47:0]        dvd_step;
    logic [31:0]        dur_prod;
    logic [60:0]        dur_scaled;
    logic [31:0]        dur_quot;
    logic [12:0]        amp;
    logic signed [16:0] sine_val;
    logic [31:0]        sine_prod;
    logic               prod_neg;
    logic [31:0]        prod_mag;
    logic [13:0]        quot_est;
    logic [15:0]        quot_rem;
    logic [13:0]        quot;
    logic [13:0]        sample_val;

    assign in_fire  = item_in.valid && item_in.ready;
    assign out_free = !out_valid_reg || result_out.ready;
    // A zero rate register stands for the default rate.
    assign rate_used = (rate_reg == 16'd0) ? RATE_DEFAULT : rate_reg;

    assign slot_wide     = {4'b0, item_in.slot_index};
    assign slot_ok       = slot_wide < SLOTS_8;
    assign step_wide     = 8'(step_now_reg);
    assign count_clamped = (item_in.step_count > SLOTS_8) ? SLOTS_8 : item_in.step_count;
    assign gain_clamped  = (item_in.gain_pct > GAIN_MAX) ? GAIN_MAX : item_in.gain_pct;

    assign playing   = step_now_reg < play_count_reg;
    assign step_done = samples_done_reg >= samples_in_step_reg;

    // Slot RAM: pitch in the upper half, duration in the lower half.
    assign ram_we = in_fire && (item_in.kind == KIND_LOAD) && slot_ok;

    tsd_ram #(
        .WIDTH (32),
        .DEPTH (STEP_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_wide[AW-1:0]),
        .wdata ({item_in.tone_hz, item_in.duration_ms}),
        .raddr (step_wide[AW-1:0]),
        .rdata (ram_rdata)
    );

    // One restoring division bit per cycle; quotient bits shift into the
    // dividend register as the dividend bits shift out.
    assign div_shifted = {rem_reg[15:0], dvd_reg[47]};
    assign div_ge      = div_shifted >= {1'b0, divisor_reg};
    assign rem_step    = div_ge ? (div_shifted - {1'b0, divisor_reg}) : div_shifted;
    assign dvd_step    = {dvd_reg[46:0], div_ge};

    assign dur_prod = {16'b0, ram_rdata[15:0]} * {16'b0, rate_used};

    // Step length in samples: the held duration-rate product divided by 1000.
    assign dur_scaled = {29'b0, dvd_reg[31:0]} * {32'b0, DUR_RECIP};
    assign dur_quot   = {9'b0, dur_scaled[60:38]};

    // Amplitude is 8000 * gain / 100, which is exactly 80 * gain.
    assign amp       = {gain_reg, 6'b0} + {2'b0, gain_reg, 4'b0};
    assign sine_val  = sine_value(phase_acc_reg[31:24]);
    assign sine_prod = {{15{sine_val[16]}}, sine_val} * {19'b0, amp};

    // Division of the magnitude by 32767: the quotient is x>>15 or one more,
    // and the remainder x - 32767*(x>>15) equals the low 15 bits plus x>>15.
    assign prod_neg   = prod_reg[31];
    assign prod_mag   = prod_neg ? (32'd0 - prod_reg) : prod_reg;
    assign quot_est   = prod_mag[28:15];
    assign quot_rem   = {1'b0, prod_mag[14:0]} + {2'b0, quot_est};
    assign quot       = (quot_rem >= SINE_FULL) ? (quot_est + 14'd1) : quot_est;
    assign sample_val = prod_neg ? (14'd0 - quot) : quot;

    always_comb
    begin
        state_next           = state_reg;
        rate_next            = rate_reg;
        play_count_next      = play_count_reg;
        step_now_next        = step_now_reg;
        samples_done_next    = samples_done_reg;
        samples_in_step_next = samples_in_step_reg;
        phase_acc_next       = phase_acc_reg;
        phase_step_next      = phase_step_reg;
        gain_next            = gain_reg;
        from_tick_next       = from_tick_reg;
        pitch_next           = pitch_reg;
        dvd_next             = dvd_reg;
        rem_next             = rem_reg;
        divisor_next         = divisor_reg;
        div_cnt_next         = div_cnt_reg;
        prod_next            = prod_reg;
        act_next             = act_reg;
        idx_next             = idx_reg;
        out_valid_next       = out_valid_reg && !result_out.ready;
        out_sample_next      = out_sample_reg;
        out_active_next      = out_active_reg;
        out_step_next        = out_step_reg;

        if (cfg.valid)
        begin
            rate_next = cfg.data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (item_in.kind)
                        KIND_LOAD:
                        begin
                            // The slot RAM write happens outside the state machine.
                        end
                        KIND_START:
                        begin
                            if (item_in.step_count != 8'd0)
                            begin
                                play_count_next = count_clamped[SW-1:0];
                                gain_next       = gain_clamped[6:0];
                                step_now_next   = '0;
                                from_tick_next  = 1'b0;
                                state_next      = ST_BEGIN;
                            end
                        end
                        KIND_STOP:
                        begin
                            play_count_next = '0;
                            step_now_next   = '0;
                        end
                        KIND_TICK:
                        begin
                            state_next = ST_CHECK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Step start; the RAM sees the step index as its read address here.
            ST_BEGIN:
            begin
                samples_done_next = '0;
                phase_acc_next    = '0;
                if (!playing)
                begin
                    samples_in_step_next = '0;
                    phase_step_next      = '0;
                    state_next           = from_tick_reg ? ST_CHECK : ST_IDLE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end

            // Slot data is out of the RAM: duration times rate is held for the
            // reciprocal multiply.
            ST_READ:
            begin
                pitch_next = ram_rdata[31:16];
                dvd_next   = {16'b0, dur_prod};
                state_next = ST_DIV_DUR;
            end

            ST_DIV_DUR:
            begin
                samples_in_step_next = dur_quot;
                if (pitch_reg == 16'd0)
                begin
                    // A rest: no phase increment, no division needed.
                    phase_step_next = '0;
                    state_next      = from_tick_reg ? ST_CHECK : ST_IDLE;
                end
                else
                begin
                    dvd_next     = {pitch_reg, 32'b0};
                    rem_next     = '0;
                    divisor_next = rate_used;
                    div_cnt_next = '0;
                    state_next   = ST_DIV_PHASE;
                end
            end

            ST_DIV_PHASE:
            begin
                dvd_next     = dvd_step;
                rem_next     = rem_step;
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    phase_step_next = dvd_step[31:0];
                    state_next      = from_tick_reg ? ST_CHECK : ST_IDLE;
                end
            end

            // A tick either moves past a finished step or renders one sample.
            ST_CHECK:
            begin
                if (playing && step_done)
                begin
                    step_now_next  = step_now_reg + STEP_ONE;
                    from_tick_next = 1'b1;
                    state_next     = ST_BEGIN;
                end
                else
                begin
                    act_next  = playing;
                    idx_next  = step_wide[4:0];
                    prod_next = (playing && (phase_step_reg != 32'd0)) ? sine_prod : 32'd0;
                    if (playing)
                    begin
                        phase_acc_next    = phase_acc_reg + phase_step_reg;
                        samples_done_next = samples_done_reg + 32'd1;
                    end
                    state_next = ST_SCALE;
                end
            end

            // Scale the product and hand the result to the output register.
            ST_SCALE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = $signed(sample_val);
                    out_active_next = act_reg;
                    out_step_next   = idx_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            rate_reg            <= RATE_DEFAULT;
            play_count_reg      <= '0;
            step_now_reg        <= '0;
            samples_done_reg    <= '0;
            samples_in_step_reg <= '0;
            phase_acc_reg       <= '0;
            phase_step_reg      <= '0;
            gain_reg            <= '0;
            from_tick_reg       <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg           <= state_next;
            rate_reg            <= rate_next;
            play_count_reg      <= play_count_next;
            step_now_reg        <= step_now_next;
            samples_done_reg    <= samples_done_next;
            samples_in_step_reg <= samples_in_step_next;
            phase_acc_reg       <= phase_acc_next;
            phase_step_reg      <= phase_step_next;
            gain_reg            <= gain_next;
            from_tick_reg       <= from_tick_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        pitch_reg      <= pitch_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        divisor_reg    <= divisor_next;
        div_cnt_reg    <= div_cnt_next;
        prod_reg       <= prod_next;
        act_reg        <= act_next;
        idx_reg        <= idx_next;
        out_sample_reg <= out_sample_next;
        out_active_reg <= out_active_next;
        out_step_reg   <= out_step_next;
    end

    assign cfg.ready               = 1'b1;
    assign item_in.ready           = (state_reg == ST_IDLE);
    assign result_out.valid        = out_valid_reg;
    assign result_out.sample       = out_sample_reg;
    assign result_out.active       = out_active_reg;
    assign result_out.current_step = out_step_reg;

endmodule

`default_nettype wire

/* bench/tone_sequence_dds_tb.sv */
// Self-checking bench for the tone sequence synthesizer: directed and random items,
// an in-bench predictor of every tick sample, and random stalls on both channels.
// Depends on tsd_pkg and the channel interfaces in tsd_if.sv.
`timescale 1ns / 1ps

module tone_sequence_dds_tb;
    import tsd_pkg::*;

    // Number of step slots in the block as instantiated.
    localparam int SLOTS = 16;
    // Cycles the bench lets pass once every expected sample is in, before it
    // touches the rate register or ends the run. A start item yields no sample
    // but keeps the shared divider busy.
    localparam int SETTLE_CYCLES = 300;
    // Cycle budget for the whole run, far above the slowest legal run.
    localparam int CYCLE_LIMIT = 6000000;
    // Length of the long output hold-off that fills the block up.
    localparam int LONG_HOLD = 400;

    // One input item as the bench sees it.
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  slot_index;
        logic [15:0] tone_hz;
        logic [15:0] duration_ms;
        logic [7:0]  step_count;
        logic [7:0]  gain_pct;
    } tone_item_t;

    // One result item: the sample that a tick produces.
    typedef struct packed {
        logic signed [13:0] sample;
        logic               active;
        logic [4:0]         current_step;
    } sample_t;

    logic clk;
    logic rst_n;

    tsd_cfg_if    cfg_ch();
    tsd_item_if   item_ch();
    tsd_result_if res_ch();

    tone_sequence_dds #(
        .STEP_SLOTS(SLOTS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_ch),
        .item_in   (item_ch),
        .result_out(res_ch)
    );

    // Samples still owed by the block, oldest first.
    sample_t pending_samples[$];

    int mismatch_count = 0;
    int items_sent = 0;
    int cycle_count = 0;

    // Idle percentages of the sender and the receiver, set per phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // A long receiver hold-off is requested by bumping hold_req_id; the
    // receiver process notices the change and counts the stretch itself.
    int hold_req_id = 0;
    int hold_req_len = 0;

    // Shadow copy of the block's state, kept by the predictor.
    logic [15:0] rate_reg;
    logic [15:0] seq_pitch [SLOTS];
    logic [15:0] seq_len_ms [SLOTS];
    logic [4:0]  seq_count;
    logic [4:0]  seq_pos;
    logic [31:0] pos_samples;
    logic [31:0] pos_length;
    logic [31:0] acc_phase;
    logic [31:0] acc_incr;
    int          seq_gain;

    // The clock runs with a 2 ns period from time zero.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: if the run has not ended after the cycle budget, something in
    // the block has hung, and the run is declared failed.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tone_sequence_dds_tb failed");
        $finish;
    end

    // A zero rate register stands for the default rate.
    function automatic logic [31:0] rate_in_use();
        return (rate_reg == 16'd0) ? {16'd0, RATE_DEFAULT} : {16'd0, rate_reg};
    endfunction

    // Full-wave sine from the quarter-wave table by mirror symmetry.
    function automatic int sine_at(input logic [7:0] idx);
        int k;
        int mag;
        k = int'(idx[6:0]);
        if (k > 64)
        begin
            k = 128 - k;
        end
        mag = int'(QUARTER_SINE[k]);
        return idx[7] ? -mag : mag;
    endfunction

    // Sets up the step at seq_pos: its length in samples and its phase
    // increment. The phase always restarts from zero. Past the end of the
    // sequence the step is empty and silent.
    task automatic enter_step();
        logic [63:0] numer;
        logic [15:0] hz;
        pos_samples = 32'd0;
        acc_phase = 32'd0;
        if (seq_pos >= seq_count || seq_pos >= 5'(SLOTS))
        begin
            pos_length = 32'd0;
            acc_incr = 32'd0;
        end
        else
        begin
            hz = seq_pitch[seq_pos[3:0]];
            pos_length = {16'd0, seq_len_ms[seq_pos[3:0]]} * rate_in_use() / 32'd1000;
            numer = {16'd0, hz, 32'd0};
            acc_incr = (hz == 16'd0) ? 32'd0 : 32'(numer / {32'd0, rate_in_use()});
        end
    endtask

    // Applies one accepted item to the shadow state and, for a tick, queues
    // the sample the block must return.
    task automatic render_item(input tone_item_t it);
        sample_t  want;
        logic [4:0] clamped;
        int       amp;
        int       value;
        case (it.kind)
            KIND_LOAD:
            begin
                if (int'(it.slot_index) < SLOTS)
                begin
                    seq_pitch[it.slot_index] = it.tone_hz;
                    seq_len_ms[it.slot_index] = it.duration_ms;
                end
            end
            KIND_START:
            begin
                // A start with no steps changes nothing at all.
                if (it.step_count != 8'd0)
                begin
                    clamped = (it.step_count > 8'(SLOTS)) ? 5'(SLOTS) : it.step_count[4:0];
                    seq_gain = (it.gain_pct > GAIN_MAX) ? int'(GAIN_MAX) : int'(it.gain_pct);
                    seq_count = clamped;
                    seq_pos = 5'd0;
                    enter_step();
                end
            end
            KIND_STOP:
            begin
                // Only the position and count are cleared; phase and gain stay.
                seq_count = 5'd0;
                seq_pos = 5'd0;
            end
            default:
            begin
                // Steps of zero length are passed over without a sample.
                while (seq_pos < seq_count && pos_samples >= pos_length)
                begin
                    seq_pos++;
                    enter_step();
                end
                want.sample = 14'sd0;
                want.active = 1'b0;
                want.current_step = seq_pos;
                if (seq_pos < seq_count)
                begin
                    want.active = 1'b1;
                    if (acc_incr != 32'd0)
                    begin
                        amp = 8000 * seq_gain / 100;
                        value = sine_at(acc_phase[31:24]) * amp / 32767;
                        want.sample = 14'(value);
                    end
                    acc_phase = acc_phase + acc_incr;
                    pos_samples = pos_samples + 32'd1;
                end
                pending_samples.push_back(want);
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    // Offers one item after a random gap and waits until the block takes it.
    // Valid is left high after the handshake so that a following item can go
    // out back to back; it is lowered only for a gap or a pause.
    task automatic send_item(input kind_t kind, input logic [3:0] slot,
                             input logic [15:0] hz, input logic [15:0] dur_ms,
                             input logic [7:0] count, input logic [7:0] gain);
        tone_item_t it;
        int gap;
        it = '{kind, slot, hz, dur_ms, count, gain};
        gap = 0;
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.kind        <= kind;
        item_ch.slot_index  <= slot;
        item_ch.tone_hz     <= hz;
        item_ch.duration_ms <= dur_ms;
        item_ch.step_count  <= count;
        item_ch.gain_pct    <= gain;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
        render_item(it);
    endtask

    // Stops offering items and waits until every expected sample is in, then
    // lets the block finish any step set-up that yields no sample.
    task automatic wait_all_samples();
        item_ch.valid <= 1'b0;
        while (pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the sample rate register; only called while the block is idle.
    task automatic write_rate(input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        rate_reg = value;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_hz();
        if ($urandom_range(5) == 0)
        begin
            return 16'd0;
        end
        return 16'($urandom_range(65535));
    endfunction

    // Mostly steps of a handful of samples at the current rate, now and then
    // any length at all.
    function automatic logic [15:0] pick_len_ms();
        int n;
        int rate;
        if ($urandom_range(11) == 0)
        begin
            return 16'($urandom_range(65535));
        end
        n = int'($urandom_range(5));
        rate = int'(rate_in_use());
        return 16'((n * 1000 + rate - 1) / rate);
    endfunction

    function automatic logic [7:0] pick_count();
        int r;
        r = int'($urandom_range(99));
        if (r < 70)
        begin
            return 8'($urandom_range(1, 6));
        end
        if (r < 80)
        begin
            return 8'd0;
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_gain();
        int r;
        r = int'($urandom_range(99));
        if (r < 15)
        begin
            return 8'd0;
        end
        if (r < 30)
        begin
            return 8'($urandom_range(100, 255));
        end
        return 8'($urandom_range(100));
    endfunction

    // Ticks before any setting, then one long step at the reset rate that is
    // cut short by a stop.
    task automatic test_reset_rate_play();
        send_item(KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        send_item(KIND_LOAD, 4'd0, 16'd1000, 16'hFFFF, 8'd0, 8'd0);
        send_item(KIND_START, 4'd0, 16'd0, 16'd0, 8'd1, 8'd100);
        repeat (3) send_item(KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        send_item(KIND_STOP, 4'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        send_item(KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 8'd0);
    endtask

    // At 1000 Hz a step of n ms is n samples, which makes the step kinds easy
    // to walk through: a tone, a rest, an empty step that is skipped, a step
    // at the top pitch, and the idle ticks after the end of the sequence.
    task automatic test_step_kinds();
        wait_all_samples();
        write_rate(16'd1000);
        send_item(KIND_LOAD, 4'd0, 16'd250, 16'd2, 8'd0, 8'd0);
        send_item(KIND_LOAD, 4'd1, 16'd0, 16'd2, 8'd0, 8'd0);
        send_item(KIND_LOAD, 4'd2, 16'd440, 16'd0, 8'd0, 8'd0);
        send_item(KIND_LOAD, 4'd3, 16'hFFFF, 16'd1, 8'd0, 8'd0);
        send_item(KIND_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        // A start with no steps must be ignored, the next one clamps the gain.
        send_item(KIND_START, 4'd0, 16'd0, 16'd0, 8'd0, 8'd50);
        send_item(KIND_START, 4'd0, 16'd0, 16'd0, 8'd4, 8'hFF);
        repeat (7) send_item(KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        send_item(KIND_STOP, 4'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        send_item(KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 8'd0);
    endtask

    // The receiver stops taking samples for a long stretch while ticks keep
    // coming, so the block has to stall its input.
    task automatic test_output_stall();
        int i;
        wait_all_samples();
        write_rate(16'd1000);
        for (i = 0; i < 6; i++)
        begin
            send_item(KIND_LOAD, 4'(i), pick_hz(), 16'($urandom_range(1, 4)), 8'd0, 8'd0);
        end
        send_item(KIND_START, 4'd0, 16'd0, 16'd0, 8'd6, 8'd80);
        hold_req_len = LONG_HOLD;
        hold_req_id++;
        repeat (60) send_item(KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 8'd0);
    endtask

    // Random play at one rate. All slots are loaded first so that any start
    // only reads written slots. Most of the traffic is start-then-ticks
    // episodes with random content; the rest is stops, reloads during play
    // and items with every field random.
    task automatic test_random_play(input logic [15:0] rate, input int n_items);
        int stop_at;
        int i;
        int r;
        int burst;
        wait_all_samples();
        write_rate(rate);
        stop_at = items_sent + n_items;
        for (i = 0; i < SLOTS; i++)
        begin
            send_item(KIND_LOAD, 4'(i), pick_hz(), pick_len_ms(), 8'd0, 8'd0);
        end
        while (items_sent < stop_at)
        begin
            r = int'($urandom_range(99));
            if (r < 10)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_item(kind_t'($urandom_range(3)), 4'($urandom_range(15)),
                              16'($urandom_range(65535)), 16'($urandom_range(65535)),
                              8'($urandom_range(255)), 8'($urandom_range(255)));
                end
            end
            else
            begin
                repeat ($urandom_range(3))
                begin
                    send_item(KIND_LOAD, 4'($urandom_range(15)), pick_hz(), pick_len_ms(),
                              8'd0, 8'd0);
                end
                send_item(KIND_START, 4'd0, 16'd0, 16'd0, pick_count(), pick_gain());
                burst = int'($urandom_range(3, 25));
                for (i = 0; i < burst; i++)
                begin
                    r = int'($urandom_range(99));
                    if (r < 6)
                    begin
                        send_item(KIND_STOP, 4'd0, 16'd0, 16'd0, 8'd0, 8'd0);
                    end
                    else if (r < 9)
                    begin
                        send_item(KIND_LOAD, 4'($urandom_range(15)), pick_hz(),
                                  pick_len_ms(), 8'd0, 8'd0);
                    end
                    else
                    begin
                        send_item(KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0, 8'd0);
                    end
                end
            end
        end
    endtask

    // Receiver: takes samples with random idle cycles, or holds off for a
    // whole stretch when one is requested.
    initial
    begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req_id != hold_seen)
            begin
                hold_seen = hold_req_id;
                hold_left = hold_req_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= (int'($urandom_range(99)) >= recv_idle_pct);
            end
        end
    end

    // Every sample taken from the block is checked against the oldest
    // expectation, field by field.
    always @(posedge clk)
    begin : check_samples
        sample_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_samples.size() == 0)
            begin
                report_mismatch($sformatf("unexpected sample %0d active %0b step %0d",
                                          res_ch.sample, res_ch.active,
                                          res_ch.current_step));
            end
            else
            begin
                want = pending_samples.pop_front();
                if (res_ch.sample !== want.sample || res_ch.active !== want.active
                    || res_ch.current_step !== want.current_step)
                begin
                    report_mismatch($sformatf(
                        "sample mismatch: expected %0d/%0b/%0d, got %0d/%0b/%0d",
                        want.sample, want.active, want.current_step,
                        res_ch.sample, res_ch.active, res_ch.current_step));
                end
            end
        end
    end

    // Main sequence: reset once, then the tests in turn under three idling
    // regimes, then drain and report.
    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.kind = KIND_LOAD;
        item_ch.slot_index = 4'd0;
        item_ch.tone_hz = 16'd0;
        item_ch.duration_ms = 16'd0;
        item_ch.step_count = 8'd0;
        item_ch.gain_pct = 8'd0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = 16'd0;

        // Shadow state as reset leaves it. Slots start at zero here, but the
        // tests never play a slot before loading it.
        rate_reg = RATE_DEFAULT;
        for (int i = 0; i < SLOTS; i++)
        begin
            seq_pitch[i] = 16'd0;
            seq_len_ms[i] = 16'd0;
        end
        seq_count = 5'd0;
        seq_pos = 5'd0;
        pos_samples = 32'd0;
        pos_length = 32'd0;
        acc_phase = 32'd0;
        acc_incr = 32'd0;
        seq_gain = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles little, receiver a lot.
        send_idle_pct = 30;
        recv_idle_pct = 69;
        test_reset_rate_play();
        test_step_kinds();
        test_random_play(16'd1, 115);
        test_random_play(16'hFFFF, 115);

        // The other way round; the zero rate falls back to the default.
        send_idle_pct = 69;
        recv_idle_pct = 30;
        test_output_stall();
        test_random_play(16'd0, 115);
        test_random_play(16'd8000, 115);

        // Full throughput on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_play(16'($urandom_range(1, 65535)), 115);
        test_random_play(16'($urandom_range(1, 65535)), 115);

        wait_all_samples();
        if (mismatch_count == 0)
        begin
            $display("tone_sequence_dds_tb passed");
        end
        else
        begin
            $display("tone_sequence_dds_tb failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/tsd_pkg.sv
rtl/tsd_if.sv
rtl/tsd_ram.sv
rtl/tone_sequence_dds.sv
bench/tone_sequence_dds_tb.sv
